@@ src/prrs_pkg.sv @@
// Package: shared types, codes and constants of the priority round robin scheduler.
`timescale 1ns / 1ps
`default_nettype none
package prrs_pkg;

	localparam int MaxTasksDefault = 64;
	localparam int QuantumReset    = 10;
	localparam int TidW   = 6;
	localparam int PrioW  = 8;
	localparam int BurstW = 16;
	localparam int WaitW  = 22;
	localparam int TurnW  = 23;
	localparam logic [WaitW-1:0] WaitMax = {WaitW{1'b1}};

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_ALL_DONE = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEVEL,
		S_MEMBER,
		S_SLICE,
		S_UPDATE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [PrioW-1:0]  prio;
		logic [BurstW-1:0] remaining;
		logic [BurstW-1:0] orig;
		logic [WaitW-1:0]  waiting;
		logic              done;
	} entry_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [TidW-1:0]   task_id;
		logic [BurstW-1:0] slice_len;
		logic              finished;
		logic [WaitW-1:0]  waiting_time;
		logic [TurnW-1:0]  turnaround_time;
	} result_t;

endpackage
`default_nettype wire

@@ src/prrs_req_if.sv @@
// Interface: request channel (command, priority, burst).
`timescale 1ns / 1ps
`default_nettype none
interface prrs_req_if;
	import prrs_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [PrioW-1:0]  priority_req;
	logic [BurstW-1:0] burst;
	modport source (output valid, cmd, priority_req, burst, input ready);
	modport sink (input valid, cmd, priority_req, burst, output ready);
endinterface
`default_nettype wire

@@ src/prrs_rsp_if.sv @@
// Interface: response channel (one result per transaction).
`timescale 1ns / 1ps
`default_nettype none
interface prrs_rsp_if;
	import prrs_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [TidW-1:0]   task_id;
	logic [BurstW-1:0] slice_len;
	logic              finished;
	logic [WaitW-1:0]  waiting_time;
	logic [TurnW-1:0]  turnaround_time;
	modport source (output valid, status, task_id, slice_len, finished, waiting_time,
		turnaround_time, input ready);
	modport sink (input valid, status, task_id, slice_len, finished, waiting_time,
		turnaround_time, output ready);
endinterface
`default_nettype wire

@@ src/priority_round_robin_scheduler_core.sv @@
// Top level: priority scheduler with round robin inside each priority level.
//
// Usage:
//   req: one transaction per command (load task, step scheduler, clear table).
//   rsp: exactly one result transaction per request, in order.
//   cfg_we/cfg_wdata: writes the quantum; only while the block is idle.
// Sequence (from acceptance to the registered result in rsp):
//   load, clear, no-op: idle, then the response state.
//   step: three linear passes over the n loaded entries through the table
//   memory's single read port, only the first when nothing is left to run:
//   find the top live level, count members and pick the round robin winner,
//   then read every entry, write back the served task's remaining burst and
//   charge waiting time to the other live ones. A slice state sits between.
// Flow: one request at a time; req.ready is high only in the idle state, so
//   a new request waits until the last one has left the response state.
//   A result sits in an output register, so the next request is accepted while
//   the receiver stalls; the following result waits until that one is taken.
// Reset: table empty, quantum 10, no task served yet. The table memory itself
//   is not cleared; only slots below the task count are ever used.
`timescale 1ns / 1ps
`default_nettype none
module priority_round_robin_scheduler_core #(
	parameter int MAX_TASKS = prrs_pkg::MaxTasksDefault
) (
	input  wire                     clk,
	input  wire                     arst_n,
	prrs_req_if.sink                req,
	prrs_rsp_if.source              rsp,
	input  wire                     cfg_we,
	input  wire [prrs_pkg::BurstW-1:0] cfg_wdata
);
	import prrs_pkg::*;

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] MaxCount = CW'(MAX_TASKS);

	state_t state_q, state_d;

	logic [BurstW-1:0] quantum_q;
	logic [CW-1:0]     count_q;      // loaded tasks
	logic [AW-1:0]     last_q;       // slot served last
	logic              served_q;     // something served since clear
	logic [CW-1:0]     c_q;          // pass counter (read issue index)
	logic [AW-1:0]     idx_s1;       // slot of the data in rd_data

	// scan state
	logic [PrioW-1:0]  level_q;
	logic              any_q;
	logic [CW-1:0]     members_q;
	logic              fa_found_q, fb_found_q, last_match_q;
	logic [AW-1:0]     fa_q, fb_q, pick_q;
	logic [BurstW-1:0] fa_rem_q, fb_rem_q, slice_q;

	result_t res_q, out_q;
	result_t res_init;
	logic    out_vld_q;

	// table
	logic    wr_en;
	logic [AW-1:0] wr_addr;
	entry_t  wr_data, rd_data;

	logic    pass_end, proc;
	logic    any_n;
	logic [PrioW-1:0] level_n;
	logic [WaitW:0]   wsum;
	logic [BurstW-1:0] new_rem, q_eff, pick_rem;
	logic    use_after;

	prrs_table #(.MAX_TASKS(MAX_TASKS), .AW(AW)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (c_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign pass_end = (c_q == count_q);
	assign proc     = (c_q != '0);

	// running max over live entries, including the entry arriving this cycle
	always_comb begin
		level_n = level_q;
		any_n   = any_q;
		if (proc && !rd_data.done && (!any_q || rd_data.prio > level_q)) begin
			level_n = rd_data.prio;
			any_n   = 1'b1;
		end
	end

	// result of a command that finishes straight from idle
	always_comb begin
		res_init = '0;
		if (cmd_t'(req.cmd) == CMD_LOAD) begin
			if (count_q < MaxCount) begin
				res_init.task_id = TidW'(count_q);
			end else begin
				res_init.status = ST_FULL;
			end
		end
	end

	assign wsum    = {1'b0, rd_data.waiting} + (WaitW+1)'(slice_q);
	assign new_rem = rd_data.remaining - slice_q;
	assign q_eff   = (quantum_q == '0) ? BurstW'(1) : quantum_q;
	assign use_after = served_q && ({1'b0, last_q} < (AW+1)'(count_q)) && last_match_q
		&& fb_found_q;
	assign pick_rem = use_after ? fb_rem_q : fa_rem_q;

	// table write port: loads and the update pass
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data;
		if (state_q == S_IDLE) begin
			wr_addr = count_q[AW-1:0];
			wr_data.prio      = req.priority_req;
			wr_data.remaining = req.burst;
			wr_data.orig      = req.burst;
			wr_data.waiting   = '0;
			wr_data.done      = (req.burst == '0);
			wr_en = req.valid && (cmd_t'(req.cmd) == CMD_LOAD) && (count_q < MaxCount);
		end else if (state_q == S_UPDATE && proc) begin
			if (idx_s1 == pick_q) begin
				wr_data.remaining = new_rem;
				wr_data.done      = (new_rem == '0);
				wr_en = 1'b1;
			end else if (!rd_data.done) begin
				wr_data.waiting = (wsum > {1'b0, WaitMax}) ? WaitMax : wsum[WaitW-1:0];
				wr_en = 1'b1;
			end
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = (cmd_t'(req.cmd) == CMD_STEP) ? S_LEVEL : S_RESP;
				end
			end
			S_LEVEL: begin
				if (pass_end) begin
					state_d = any_n ? S_MEMBER : S_RESP;
				end
			end
			S_MEMBER: begin
				if (pass_end) begin
					state_d = S_SLICE;
				end
			end
			S_SLICE:  state_d = S_UPDATE;
			S_UPDATE: begin
				if (pass_end) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= BurstW'(QuantumReset);
			count_q   <= '0;
			last_q    <= '0;
			served_q  <= 1'b0;
			out_vld_q <= 1'b0;
			c_q       <= '0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			// output register: load a new result, or drop a taken one
			if (state_q == S_RESP && (!out_vld_q || rsp.ready)) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					c_q <= '0;
					if (req.valid) begin
						case (cmd_t'(req.cmd))
							CMD_LOAD: begin
								if (count_q < MaxCount) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_CLEAR: begin
								count_q  <= '0;
								last_q   <= '0;
								served_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_LEVEL, S_MEMBER, S_UPDATE: begin
					c_q <= pass_end ? '0 : c_q + CW'(1);
					if (state_q == S_UPDATE && pass_end) begin
						last_q   <= pick_q;
						served_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= c_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				any_q        <= 1'b0;
				members_q    <= '0;
				fa_found_q   <= 1'b0;
				fb_found_q   <= 1'b0;
				last_match_q <= 1'b0;
				res_q        <= res_init;
			end
			S_LEVEL: begin
				level_q <= level_n;
				any_q   <= any_n;
				if (pass_end && !any_n) begin
					res_q.status <= ST_ALL_DONE;
				end
			end
			S_MEMBER: begin
				if (proc && rd_data.prio == level_q) begin
					members_q <= members_q + CW'(1);
					if (idx_s1 == last_q) begin
						last_match_q <= 1'b1;
					end
					if (!rd_data.done) begin
						if (!fa_found_q) begin
							fa_found_q <= 1'b1;
							fa_q       <= idx_s1;
							fa_rem_q   <= rd_data.remaining;
						end
						if (!fb_found_q && idx_s1 > last_q) begin
							fb_found_q <= 1'b1;
							fb_q       <= idx_s1;
							fb_rem_q   <= rd_data.remaining;
						end
					end
				end
			end
			S_SLICE: begin
				pick_q <= use_after ? fb_q : fa_q;
				slice_q <= (members_q > CW'(1) && pick_rem > q_eff) ? q_eff : pick_rem;
			end
			S_UPDATE: begin
				if (proc && idx_s1 == pick_q) begin
					res_q.task_id   <= TidW'(pick_q);
					res_q.slice_len <= slice_q;
					if (new_rem == '0) begin
						res_q.finished        <= 1'b1;
						res_q.waiting_time    <= rd_data.waiting;
						res_q.turnaround_time <= TurnW'(rd_data.waiting) + TurnW'(rd_data.orig);
					end
				end
			end
			S_RESP: begin
				if (!out_vld_q || rsp.ready) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_q.status;
	assign rsp.task_id         = out_q.task_id;
	assign rsp.slice_len       = out_q.slice_len;
	assign rsp.finished        = out_q.finished;
	assign rsp.waiting_time    = out_q.waiting_time;
	assign rsp.turnaround_time = out_q.turnaround_time;
endmodule
`default_nettype wire

@@ src/prrs_table.sv @@
// Task table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module prrs_table #(
	parameter int MAX_TASKS = prrs_pkg::MaxTasksDefault,
	parameter int AW        = $clog2(MAX_TASKS)
) (
	input  wire                  clk,
	input  wire                  wr_en,
	input  wire  [AW-1:0]        wr_addr,
	input  prrs_pkg::entry_t     wr_data,
	input  wire  [AW-1:0]        rd_addr,
	output prrs_pkg::entry_t     rd_data
);
	import prrs_pkg::*;

	entry_t mem_q [MAX_TASKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

@@ bench/priority_round_robin_scheduler_core_tb.sv @@
// Testbench: checks the priority round robin scheduler against a task table predictor.
`timescale 1ns / 1ps
`default_nettype none
module priority_round_robin_scheduler_core_tb;
	import prrs_pkg::*;

	localparam int NumSlots = MaxTasksDefault;
	localparam int IdleLimit = 20000;

	// expected result of one transaction
	typedef struct {
		status_t           status;
		logic [TidW-1:0]   task_id;
		logic [BurstW-1:0] slice_len;
		logic              finished;
		logic [WaitW-1:0]  waiting_time;
		logic [TurnW-1:0]  turnaround_time;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [BurstW-1:0] cfg_wdata = '0;

	prrs_req_if req ();
	prrs_rsp_if rsp ();

	priority_round_robin_scheduler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor copy of the task table
	logic [PrioW-1:0]  tbl_prio [NumSlots];
	logic [BurstW-1:0] tbl_left [NumSlots];
	logic [BurstW-1:0] tbl_orig [NumSlots];
	logic [WaitW-1:0]  tbl_wait [NumSlots];
	logic              tbl_done [NumSlots];
	int unsigned       tbl_count;
	int unsigned       last_pick;
	logic              any_served;
	logic [BurstW-1:0] quantum_shadow;

	sched_result_t expected_results[$];
	int unsigned   failures;
	int unsigned   results_seen;
	int unsigned   items_sent;
	int unsigned   finish_count;
	int unsigned   idle_cycles;
	logic          rsp_stall_enable;

	function automatic void empty_table();
		tbl_count = 0;
		last_pick = 0;
		any_served = 1'b0;
	endfunction

	// work out the result of one command and update the table copy
	function automatic sched_result_t predict_command(cmd_t cmd, logic [PrioW-1:0] prio,
			logic [BurstW-1:0] burst);
		sched_result_t r;
		int unsigned level, members, start, pick, k, q, slice, w;
		logic any, found;
		r = '{ST_OK, '0, '0, 1'b0, '0, '0};
		case (cmd)
			CMD_LOAD: begin
				if (tbl_count >= NumSlots) begin
					r.status = ST_FULL;
				end else begin
					tbl_prio[tbl_count] = prio;
					tbl_left[tbl_count] = burst;
					tbl_orig[tbl_count] = burst;
					tbl_wait[tbl_count] = '0;
					tbl_done[tbl_count] = (burst == 0);
					r.task_id = tbl_count[TidW-1:0];
					tbl_count++;
				end
			end
			CMD_STEP: begin
				any = 1'b0;
				level = 0;
				for (int i = 0; i < tbl_count; i++)
					if (!tbl_done[i] && (!any || tbl_prio[i] > level)) begin
						level = 32'(tbl_prio[i]);
						any = 1'b1;
					end
				if (!any) begin
					r.status = ST_ALL_DONE;
					return r;
				end
				members = 0;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_prio[i] == level) members++;
				// a new level starts its search at slot 0
				start = 0;
				if (any_served && last_pick < tbl_count && tbl_prio[last_pick] == level)
					start = last_pick + 1;
				found = 1'b0;
				pick = 0;
				for (int i = 0; i < tbl_count && !found; i++) begin
					k = start + i;
					if (k >= tbl_count) k -= tbl_count;
					if (!tbl_done[k] && tbl_prio[k] == level) begin
						pick = k;
						found = 1'b1;
					end
				end
				q = (quantum_shadow == 0) ? 1 : 32'(quantum_shadow);
				slice = 32'(tbl_left[pick]);
				if (members > 1 && slice > q) slice = q;
				tbl_left[pick] = tbl_left[pick] - slice[BurstW-1:0];
				if (tbl_left[pick] == 0) tbl_done[pick] = 1'b1;
				// charge everyone else still waiting, saturating
				for (int i = 0; i < tbl_count; i++)
					if (i != pick && !tbl_done[i]) begin
						w = 32'(tbl_wait[i]) + slice;
						tbl_wait[i] = (w > WaitMax) ? WaitMax : w[WaitW-1:0];
					end
				last_pick = pick;
				any_served = 1'b1;
				r.task_id = pick[TidW-1:0];
				r.slice_len = slice[BurstW-1:0];
				if (tbl_done[pick]) begin
					r.finished = 1'b1;
					r.waiting_time = tbl_wait[pick];
					r.turnaround_time = TurnW'(tbl_wait[pick]) + TurnW'(tbl_orig[pick]);
				end
			end
			CMD_CLEAR: empty_table();
			default: ;
		endcase
		return r;
	endfunction

	// send one transaction after a random gap unless no_gap is set; prediction happens at acceptance
	// valid is left high after acceptance; the block is busy then, and the next
	// send or drain decides what valid does at the following falling edge
	task automatic send_command(cmd_t cmd, logic [PrioW-1:0] prio, logic [BurstW-1:0] burst,
			bit no_gap = 0);
		int unsigned gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.priority_req <= prio;
		req.burst <= burst;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		expected_results.push_back(predict_command(cmd, prio, burst));
		items_sent++;
		@(negedge clk);
	endtask

	// wait for every expected result, then for the block to settle
	task automatic drain();
		req.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (3 * NumSlots + 20) @(negedge clk);
	endtask

	// quantum writes only while idle
	task automatic write_quantum(logic [BurstW-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		quantum_shadow = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver stall pattern: a random wait per result, sometimes none at all
	initial begin
		rsp.ready = 1'b0;
		forever begin
			int unsigned stall;
			@(negedge clk);
			stall = rsp_stall_enable ? $urandom_range(0, 9) : 0;
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp.valid && rsp.ready)) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			sched_result_t e;
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				failures++;
			end else begin
				e = expected_results.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, rsp.status);
					failures++;
				end
				if (rsp.task_id !== e.task_id) begin
					$error("task_id: expected %0d actual %0d", e.task_id, rsp.task_id);
					failures++;
				end
				if (rsp.slice_len !== e.slice_len) begin
					$error("slice_len: expected %0d actual %0d", e.slice_len, rsp.slice_len);
					failures++;
				end
				if (rsp.finished !== e.finished) begin
					$error("finished: expected %0d actual %0d", e.finished, rsp.finished);
					failures++;
				end
				if (rsp.waiting_time !== e.waiting_time) begin
					$error("waiting_time: expected %0d actual %0d", e.waiting_time,
						rsp.waiting_time);
					failures++;
				end
				if (rsp.turnaround_time !== e.turnaround_time) begin
					$error("turnaround_time: expected %0d actual %0d", e.turnaround_time,
						rsp.turnaround_time);
					failures++;
				end
				if (e.finished) finish_count++;
			end
		end
	end

	// watchdog: any stretch with no transaction on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// directed: field extremes, every command, zero burst, empty step, no-op
	task automatic test_directed();
		send_command(CMD_STEP, 8'h00, 16'h0000);
		send_command(CMD_LOAD, 8'hFF, 16'hFFFF);
		send_command(CMD_LOAD, 8'h00, 16'h0000);
		send_command(CMD_LOAD, 8'hFF, 16'h0015);
		send_command(CMD_LOAD, 8'h00, 16'h0003);
		send_command(CMD_NOP, 8'hA5, 16'h5A5A);
		repeat (6) send_command(CMD_STEP, 8'h00, 16'h0000);
		send_command(CMD_CLEAR, 8'hFF, 16'hFFFF);
		send_command(CMD_STEP, 8'h00, 16'h0000);
		// single-task level runs the whole burst
		send_command(CMD_LOAD, 8'h55, 16'h8000);
		send_command(CMD_LOAD, 8'hAA, 16'h7FFF);
		repeat (3) send_command(CMD_STEP, 8'h00, 16'h0000);
		send_command(CMD_CLEAR, 8'h00, 16'h0000);
	endtask

	// quantum zero acts as one
	task automatic test_quantum_zero();
		write_quantum(16'h0000);
		send_command(CMD_LOAD, 8'h10, 16'h0002);
		send_command(CMD_LOAD, 8'h10, 16'h0002);
		repeat (5) send_command(CMD_STEP, 8'h00, 16'h0000);
		send_command(CMD_CLEAR, 8'h00, 16'h0000);
	endtask

	// fill the table past its end, then push waiting times toward their limit
	task automatic test_full_and_saturation();
		write_quantum(16'hFFFF);
		for (int i = 0; i < NumSlots + 2; i++)
			send_command(CMD_LOAD, (i < 2) ? 8'h01 : 8'h80, 16'hFFFF, 1);
		// 62 top-level tasks share slices of the full quantum
		for (int i = 0; i < 140; i++) send_command(CMD_STEP, 8'h00, 16'h0000, 1);
		send_command(CMD_CLEAR, 8'h00, 16'h0000);
	endtask

	// random workload sets: mostly loads followed by steps, some noise
	task automatic test_random(int unsigned sets);
		cmd_t c;
		int unsigned n_load, n_step, prio_span;
		for (int s = 0; s < sets; s++) begin
			if (s % 8 == 0) begin
				case ($urandom_range(0, 3))
					0: write_quantum(16'h0001);
					1: write_quantum(16'hFFFF);
					default: write_quantum(BurstW'($urandom_range(1, 40)));
				endcase
			end
			rsp_stall_enable = ($urandom_range(0, 4) != 0);
			n_load = $urandom_range(1, 10);
			prio_span = $urandom_range(0, 3);
			for (int i = 0; i < n_load; i++)
				send_command(CMD_LOAD, PrioW'(($urandom_range(0, 3) == 0)
					? $urandom_range(0, 255) : 200 + $urandom_range(0, prio_span)),
					BurstW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 60)));
			n_step = $urandom_range(n_load, 3 * n_load + 4);
			for (int i = 0; i < n_step; i++) begin
				c = cmd_t'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : CMD_STEP);
				send_command(c, PrioW'($urandom_range(0, 255)),
					BurstW'($urandom_range(0, 65535)));
			end
			if ($urandom_range(0, 1))
				send_command(CMD_CLEAR, PrioW'($urandom), BurstW'($urandom));
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_NOP;
		req.priority_req = '0;
		req.burst = '0;
		failures = 0;
		results_seen = 0;
		items_sent = 0;
		finish_count = 0;
		idle_cycles = 0;
		rsp_stall_enable = 1'b1;
		quantum_shadow = BurstW'(QuantumReset);
		empty_table();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_quantum_zero();
		test_full_and_saturation();
		test_random(60);
		drain();
		if (expected_results.size() != 0) begin
			$error("results still expected at end: %0d", expected_results.size());
			failures++;
		end
		$display("Covered %0d transactions with %0d results, %0d task completions,",
			items_sent, results_seen, finish_count);
		$display("quanta from 0 to 65535, a full table and waiting times near the top.");
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
